>>> rtl/core/smss_pkg.sv
`timescale 1ns / 1ps
package smss_pkg;
  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned IndexBitsDef  = 16;
  localparam logic [7:0]  DefaultByteRst = 8'd48;
  localparam logic [0:0]  OpRead  = 1'b0;
  localparam logic [0:0]  OpWrite = 1'b1;
  localparam logic [0:0]  RegDefaultByte = 1'b0;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StSearchWait,
    StDecide,
    StShiftRd,
    StShiftWr,
    StPlace,
    StScanRd,
    StScan,
    StDone
  } state_e;
endpackage

>>> rtl/core/smss_mem.sv
`timescale 1ns / 1ps
module smss_mem import smss_pkg::*; #(
  parameter int unsigned Depth = TableDepthDef,
  parameter int unsigned Width = 40,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/sparse_matrix_sorted_store_unit.sv
`timescale 1ns / 1ps
// Sparse byte matrix kept as a sorted (row, col, value) list in one single-port-read
// memory. Each request takes a binary search (log2 of the entry count probes); a write
// that inserts or deletes then shifts up to entries_used entries through the same memory
// port, and every request ends with a full scan of the stored entries to build the row
// and column min/max and the nondefault count. in_stall_o stays high until the
// result is taken.
module sparse_matrix_sorted_store_unit import smss_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned IndexBits  = IndexBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  op_i,
  input  logic [15:0] row_index_i,
  input  logic [15:0] col_index_i,
  input  logic [7:0]  write_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_byte_o,
  output logic [8:0]  entries_used_o,
  output logic [8:0]  nondefault_count_o,
  output logic [15:0] lowest_row_o,
  output logic [15:0] highest_row_o,
  output logic [15:0] lowest_col_o,
  output logic [15:0] highest_col_o,
  output logic        is_empty_o,
  output logic        insert_dropped_o
);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = 2 * IndexBits + 8;

  state_e state_q, state_d;
  logic [7:0] dflt_q;
  logic [CW-1:0] cnt_q, cnt_d, lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [CW-1:0] nd_q, nd_d;
  logic op_q;
  logic [IndexBits-1:0] row_q, col_q, cmin_q, cmin_d, cmax_q, cmax_d;
  logic [IndexBits-1:0] rmin_q, rmin_d, rmax_q, rmax_d;
  logic [7:0] wb_q, rd_q, rd_d;
  logic drop_q, drop_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [IndexBits-1:0] e_row, e_col;
  logic [7:0] e_val;
  logic [CW-1:0] mid;
  logic found;
  logic found_q;

  smss_mem #(.Depth(TableDepth), .Width(EW), .AddrW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign e_row = rdata[EW-1 -: IndexBits];
  assign e_col = rdata[8 +: IndexBits];
  assign e_val = rdata[7:0];
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);

  assign pready = 1'b1;
  assign prdata = {24'd0, dflt_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DefaultByteRst;
    end else if (psel && penable && pwrite && paddr == RegDefaultByte) begin
      dflt_q <= pwdata[7:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:       if (in_valid_i) state_d = StSearch;
      StSearch:     state_d = (lo_q < hi_q) ? StSearchWait : StDecide;
      StSearchWait: state_d = StSearch;
      StDecide: begin
        if (op_q != OpWrite) state_d = StScanRd;
        else if (found) state_d = (wb_q == dflt_q) ? StShiftRd : StPlace;
        else if (wb_q == dflt_q || cnt_q >= CW'(TableDepth)) state_d = StScanRd;
        else state_d = StShiftRd;
      end
      StShiftRd:    state_d = StShiftWr;
      StShiftWr:    state_d = StShiftRd;
      StPlace:      state_d = StScanRd;
      StScanRd:     state_d = StScan;
      StScan:       if (ptr_q >= cnt_q) state_d = StDone;
      StDone:       if (!out_stall_i) state_d = StIdle;
      default:      state_d = StIdle;
    endcase
    // shift loop exits
    if (state_q == StShiftRd) begin
      if (found_q && ptr_q + 1'b1 >= cnt_q) state_d = StScanRd;
      if (!found_q && ptr_q <= lo_q) state_d = StPlace;
    end
  end

  // lo_q holds the found position; in StDecide the memory holds entry lo_q
  assign found = (lo_q < cnt_q) && e_row == row_q && e_col == col_q;

  always_comb begin
    we = 1'b0;
    waddr = ptr_q[AW-1:0];
    wdata = rdata;
    raddr = mid[AW-1:0];
    lo_d = lo_q; hi_d = hi_q; ptr_d = ptr_q; cnt_d = cnt_q;
    rd_d = rd_q; drop_d = drop_q; nd_d = nd_q;
    cmin_d = cmin_q; cmax_d = cmax_q; rmin_d = rmin_q; rmax_d = rmax_q;
    unique case (state_q)
      StIdle: begin
        lo_d = '0; hi_d = cnt_q; drop_d = 1'b0;
      end
      StSearch: raddr = mid[AW-1:0];
      StSearchWait: begin
        raddr = mid[AW-1:0];
        if ({e_row, e_col} < {row_q, col_q}) lo_d = mid + 1'b1;
        else hi_d = mid;
      end
      StDecide: begin
        raddr = lo_q[AW-1:0];
        rd_d = dflt_q;
        if (op_q != OpWrite) begin
          if (found) rd_d = e_val;
        end else if (found) begin
          ptr_d = lo_q;
          if (wb_q != dflt_q) rd_d = wb_q;
        end else if (wb_q != dflt_q) begin
          if (cnt_q >= CW'(TableDepth)) drop_d = 1'b1;
          else begin
            ptr_d = cnt_q; rd_d = wb_q;
          end
        end
      end
      StShiftRd: begin
        if (found_q) raddr = AW'(ptr_q + 1'b1);
        else raddr = AW'(ptr_q - 1'b1);
        if (found_q && ptr_q + 1'b1 >= cnt_q) cnt_d = cnt_q - 1'b1;
        if (!found_q && ptr_q <= lo_q) cnt_d = cnt_q + 1'b1;
      end
      StShiftWr: begin
        we = 1'b1;
        if (found_q) ptr_d = ptr_q + 1'b1;
        else ptr_d = ptr_q - 1'b1;
      end
      StPlace: begin
        we = 1'b1;
        waddr = lo_q[AW-1:0];
        wdata = {row_q, col_q, wb_q};
      end
      StScanRd: begin
        raddr = '0; ptr_d = '0; nd_d = '0;
        cmin_d = '0; cmax_d = '0; rmin_d = '0; rmax_d = '0;
      end
      StScan: begin
        raddr = AW'(ptr_q + 1'b1);
        if (ptr_q < cnt_q) begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q == '0) begin
            rmin_d = e_row; cmin_d = e_col; cmax_d = e_col;
          end else begin
            if (e_col < cmin_q) cmin_d = e_col;
            if (e_col > cmax_q) cmax_d = e_col;
          end
          rmax_d = e_row;
          if (e_val != dflt_q) nd_d = nd_q + 1'b1;
        end
      end
      StDone: ;
      default: ;
    endcase
  end

  // found is held stable across the shift: lo_q entry is only rewritten in StPlace/StShiftWr
  // so latch it for the shift phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) found_q <= 1'b0;
    else if (state_q == StDecide) found_q <= found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      op_q  <= op_i;
      row_q <= row_index_i[IndexBits-1:0];
      col_q <= col_index_i[IndexBits-1:0];
      wb_q  <= write_byte_i;
    end
    lo_q <= lo_d; hi_q <= hi_d; ptr_q <= ptr_d; rd_q <= rd_d; drop_q <= drop_d;
    nd_q <= nd_d; cmin_q <= cmin_d; cmax_q <= cmax_d; rmin_q <= rmin_d; rmax_q <= rmax_d;
  end

  assign in_stall_o         = state_q != StIdle;
  assign out_valid_o        = state_q == StDone;
  assign read_byte_o        = rd_q;
  assign entries_used_o     = 9'(cnt_q);
  assign nondefault_count_o = 9'(nd_q);
  assign lowest_row_o       = 16'(rmin_q);
  assign highest_row_o      = 16'(rmax_q);
  assign lowest_col_o       = 16'(cmin_q);
  assign highest_col_o      = 16'(cmax_q);
  assign is_empty_o         = cnt_q == '0;
  assign insert_dropped_o   = drop_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TableDepth)) else $error("entry count overflow");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && insert_dropped_o |-> cnt_q == CW'(TableDepth))
    else $error("drop while not full");
  a_nd_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nd_q <= cnt_q) else $error("nondefault exceeds count");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> rmax_q == '0 && cmax_q == '0)
    else $error("empty table with nonzero bounds");
endmodule

>>> bench/tb_sparse_matrix_sorted_store_unit.sv
`timescale 1ns / 1ps
module tb_sparse_matrix_sorted_store_unit;
  import smss_pkg::*;

  localparam int unsigned Depth     = TableDepthDef;
  localparam int unsigned PoolSize  = 160;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [8:0]  entries_used;
    logic [8:0]  nondefault_count;
    logic [15:0] lowest_row;
    logic [15:0] highest_row;
    logic [15:0] lowest_col;
    logic [15:0] highest_col;
    logic        is_empty;
    logic        insert_dropped;
  } cell_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = RegDefaultByte;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  op_i = OpRead;
  logic [15:0] row_index_i = '0;
  logic [15:0] col_index_i = '0;
  logic [7:0]  write_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_byte_o;
  logic [8:0]  entries_used_o;
  logic [8:0]  nondefault_count_o;
  logic [15:0] lowest_row_o;
  logic [15:0] highest_row_o;
  logic [15:0] lowest_col_o;
  logic [15:0] highest_col_o;
  logic        is_empty_o;
  logic        insert_dropped_o;

  // local copy of the store
  logic [15:0] cell_row [Depth];
  logic [15:0] cell_col [Depth];
  logic [7:0]  cell_val [Depth];
  int unsigned cell_count = 0;
  logic [7:0]  dflt_byte = DefaultByteRst;

  cell_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  bit           no_idle = 1'b0;
  logic [15:0]  pool_row [PoolSize];
  logic [15:0]  pool_col [PoolSize];

  always #1 clk_i = ~clk_i;

  sparse_matrix_sorted_store_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .row_index_i, .col_index_i, .write_byte_i,
    .out_valid_o, .out_stall_i, .read_byte_o, .entries_used_o, .nondefault_count_o,
    .lowest_row_o, .highest_row_o, .lowest_col_o, .highest_col_o, .is_empty_o,
    .insert_dropped_o
  );

  function automatic cell_result_t apply_cell_op(logic [0:0] op, logic [15:0] r,
                                                 logic [15:0] c, logic [7:0] wb);
    int unsigned pos;
    int unsigned i;
    bit hit;
    cell_result_t res;
    pos = 0;
    while (pos < cell_count && {cell_row[pos], cell_col[pos]} < {r, c}) pos++;
    hit = pos < cell_count && cell_row[pos] == r && cell_col[pos] == c;
    res = '0;
    res.read_byte = dflt_byte;
    if (op == OpWrite) begin
      if (hit) begin
        if (wb == dflt_byte) begin
          for (i = pos; i + 1 < cell_count; i++) begin
            cell_row[i] = cell_row[i+1];
            cell_col[i] = cell_col[i+1];
            cell_val[i] = cell_val[i+1];
          end
          cell_count--;
        end else begin
          cell_val[pos] = wb;
          res.read_byte = wb;
        end
      end else if (wb != dflt_byte) begin
        if (cell_count >= Depth) begin
          res.insert_dropped = 1'b1;
        end else begin
          for (i = cell_count; i > pos; i--) begin
            cell_row[i] = cell_row[i-1];
            cell_col[i] = cell_col[i-1];
            cell_val[i] = cell_val[i-1];
          end
          cell_row[pos] = r;
          cell_col[pos] = c;
          cell_val[pos] = wb;
          cell_count++;
          res.read_byte = wb;
        end
      end
    end else if (hit) begin
      res.read_byte = cell_val[pos];
    end
    res.entries_used = cell_count[8:0];
    res.is_empty = cell_count == 0;
    if (cell_count > 0) begin
      res.lowest_row  = cell_row[0];
      res.highest_row = cell_row[cell_count-1];
      res.lowest_col  = cell_col[0];
      res.highest_col = cell_col[0];
      for (i = 0; i < cell_count; i++) begin
        if (cell_col[i] < res.lowest_col) res.lowest_col = cell_col[i];
        if (cell_col[i] > res.highest_col) res.highest_col = cell_col[i];
        if (cell_val[i] != dflt_byte) res.nondefault_count++;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // valid stays high after an accept; it drops only when a gap follows or the bench drains
  task automatic send_request(logic [0:0] op, logic [15:0] r, logic [15:0] c,
                              logic [7:0] wb);
    int unsigned gap;
    bit stalled;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i <= op;
    row_index_i <= r;
    col_index_i <= c;
    write_byte_i <= wb;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_results.push_back(apply_cell_op(op, r, c, wb));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_default(logic [7:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegDefaultByte;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    dflt_byte = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result side: random stall before each result
  initial begin : out_stall_gen
    int unsigned n;
    bit taken;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o && !out_stall_i;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  always @(negedge clk_i) begin : result_check
    cell_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (read_byte_o != want.read_byte)
          report_mismatch("read_byte", read_byte_o, want.read_byte);
        if (entries_used_o != want.entries_used)
          report_mismatch("entries_used", entries_used_o, want.entries_used);
        if (nondefault_count_o != want.nondefault_count)
          report_mismatch("nondefault_count", nondefault_count_o, want.nondefault_count);
        if (lowest_row_o != want.lowest_row)
          report_mismatch("lowest_row", lowest_row_o, want.lowest_row);
        if (highest_row_o != want.highest_row)
          report_mismatch("highest_row", highest_row_o, want.highest_row);
        if (lowest_col_o != want.lowest_col)
          report_mismatch("lowest_col", lowest_col_o, want.lowest_col);
        if (highest_col_o != want.highest_col)
          report_mismatch("highest_col", highest_col_o, want.highest_col);
        if (is_empty_o != want.is_empty)
          report_mismatch("is_empty", is_empty_o, want.is_empty);
        if (insert_dropped_o != want.insert_dropped)
          report_mismatch("insert_dropped", insert_dropped_o, want.insert_dropped);
      end
    end
  end

  always @(negedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("** sparse_matrix_sorted_store_unit: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OpRead, 16'h0000, 16'h0000, 8'h00);   // empty table
    send_request(OpWrite, 16'h1234, 16'h5678, DefaultByteRst);  // default to absent cell
    send_request(OpWrite, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(OpWrite, 16'h0000, 16'h0000, 8'h00);
    send_request(OpWrite, 16'h0000, 16'hFFFF, 8'hA5);
    send_request(OpWrite, 16'hFFFF, 16'h0000, 8'h5A);
    send_request(OpWrite, 16'h8000, 16'h8000, 8'h01);
    send_request(OpRead, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(OpRead, 16'h0000, 16'hFFFF, 8'h00);
    send_request(OpRead, 16'h7FFF, 16'h7FFF, 8'h00);
    send_request(OpWrite, 16'h8000, 16'h8000, 8'h7E);  // update in place
    send_request(OpRead, 16'h8000, 16'h8000, 8'h00);
    send_request(OpWrite, 16'h0000, 16'h0000, DefaultByteRst);  // delete
    send_request(OpRead, 16'h0000, 16'h0000, 8'h00);
    send_request(OpWrite, 16'hFFFF, 16'hFFFF, DefaultByteRst);
    send_request(OpWrite, 16'h0000, 16'hFFFF, DefaultByteRst);
    send_request(OpWrite, 16'hFFFF, 16'h0000, DefaultByteRst);
    send_request(OpWrite, 16'h8000, 16'h8000, DefaultByteRst);  // back to empty
    send_request(OpRead, 16'h8000, 16'h8000, 8'h00);
  endtask

  task automatic test_full_table();
    int unsigned i;
    no_idle = 1'b1;
    for (i = 0; i < Depth; i++)
      send_request(OpWrite, 16'(i * 37 % 251), 16'($urandom), 8'($urandom_range(49, 255)));
    no_idle = 1'b0;
    send_request(OpWrite, 16'hFFFF, 16'hFFFF, 8'h11);  // dropped, table full
    send_request(OpWrite, 16'h0000, 16'h0000, 8'h22);
    send_request(OpRead, 16'hFFFF, 16'hFFFF, 8'h00);
    send_request(OpWrite, cell_row[10], cell_col[10], 8'h99);  // update while full
    send_request(OpWrite, cell_row[0], cell_col[0], dflt_byte);
    send_request(OpWrite, 16'hFFFF, 16'hFFFF, 8'h11);  // room again
    send_request(OpWrite, 16'h0001, 16'h0001, 8'h33);
    wait_drained();
    // empty it again, highest first
    while (cell_count > 0)
      send_request(OpWrite, cell_row[cell_count-1], cell_col[cell_count-1], dflt_byte);
  endtask

  task automatic test_default_changes();
    int unsigned i;
    for (i = 0; i < 8; i++)
      send_request(OpWrite, pool_row[i], pool_col[i], 8'(i * 32));
    write_default(8'h00);
    send_request(OpRead, pool_row[0], pool_col[0], 8'h00);
    send_request(OpWrite, pool_row[1], pool_col[1], 8'h00);
    write_default(8'hFF);
    send_request(OpRead, pool_row[2], pool_col[2], 8'h00);
    send_request(OpWrite, pool_row[3], pool_col[3], 8'h20);
    send_request(OpWrite, 16'h4444, 16'h4444, 8'hFF);
    write_default(8'd48);
  endtask

  task automatic test_random_mix(int unsigned count);
    int unsigned i;
    int unsigned k;
    logic [15:0] r;
    logic [15:0] c;
    logic [7:0] wb;
    logic [0:0] op;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = $urandom_range(0, 3) == 0;
      if (i == count / 2) begin
        wait_drained();  // let everything settle once
        write_default(8'($urandom));
      end
      k = $urandom_range(0, PoolSize - 1);
      r = pool_row[k];
      c = pool_col[k];
      if ($urandom_range(0, 9) == 0) begin
        r = 16'($urandom);
        c = 16'($urandom);
      end
      op = $urandom_range(0, 99) < 60 ? OpWrite : OpRead;
      wb = $urandom_range(0, 3) == 0 ? dflt_byte : 8'($urandom);
      send_request(op, r, c, wb);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < PoolSize; i++) begin
      pool_row[i] = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      pool_col[i] = 16'($urandom);
    end
    pool_row[0] = 16'h0000;
    pool_col[0] = 16'h0000;
    pool_row[1] = 16'hFFFF;
    pool_col[1] = 16'hFFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_default_changes();
    test_random_mix(1200);
    wait_drained();
    repeat (1000) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** sparse_matrix_sorted_store_unit: PASSED **");
    end else begin
      $display("** sparse_matrix_sorted_store_unit: FAILED **");
    end
    $finish;
  end

endmodule
